// File: src/fprd_pkg.sv
package fprd_pkg;

  // Fixed field widths of the item and of the registers.
  localparam int RADIX_W     = 6;
  localparam int PREC_W      = 5;
  localparam int CHAR_W      = 7;
  localparam int STORE_DEPTH = 32;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int COUNT_W     = STORE_AW + 1;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [PREC_W-1:0]  PREC_RESET  = 5'd9;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  // Register indexes on the configuration port (byte address 4 * index).
  localparam logic REG_RADIX     = 1'b0;
  localparam logic REG_PRECISION = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_DOT  = 7'h2E;
  localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RD,
    S_EMIT_INT,
    S_DOT,
    S_FRAC
  } fprd_state_t;

  // Clamp the programmed radix into the supported range.
  function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  // Map a digit value to its ASCII glyph; values above 35 wrap modulo 36.
  function automatic logic [CHAR_W-1:0] glyph(input logic [RADIX_W-1:0] d);
    logic [RADIX_W-1:0] m;
    logic [CHAR_W-1:0]  res;
    m = (d >= RADIX_MAX) ? d - RADIX_MAX : d;
    if (m < 6'd10) res = CHAR_ZERO + CHAR_W'(m);
    else res = CHAR_A + CHAR_W'(m - 6'd10);
    return res;
  endfunction

endpackage

// File: src/fprd_ram.sv
module fprd_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/fprd_div.sv
// Restoring divider: one quotient bit per cycle.
module fprd_div import fprd_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [WIDTH-1:0]   dividend,
  input  logic [RADIX_W-1:0] divisor,
  output logic               done,
  output logic [WIDTH-1:0]   quotient,
  output logic [RADIX_W-1:0] remainder
);

  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0]   quo;
  logic [RADIX_W-1:0] rem;
  logic [RADIX_W-1:0] dvs;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [RADIX_W:0]   trial;
  logic               ge;

  assign trial = {rem, quo[WIDTH-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        quo <= {quo[WIDTH-2:0], ge};
        rem <= ge ? RADIX_W'(trial - {1'b0, dvs}) : trial[RADIX_W-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> remainder < dvs)
    else $error("divider remainder not below divisor");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a running division");

endmodule

// File: src/fixed_point_to_radix_digits_core.sv
// Converts an unsigned fixed-point value (INT_BITS integer bits in the low
// bits of value_int, FRAC_BITS fraction bits in the low bits of value_frac)
// into its ASCII text in the programmed radix (2 to 36; other values clamp),
// one character per output item: the integer digits most significant first
// (none when the integer part is zero), then '.', then up to "precision"
// fraction digits, stopping early once the fraction is zero, or a single '0'
// when no fraction digit comes out. tlast marks the final character.
// Each integer digit comes from one division in the bit-serial shared divider
// and is kept in the digit buffer, read back through S_RD and S_EMIT_INT per
// digit; the point and the fraction digits follow. The block takes a new item
// only when the previous one has been fully sent into the output register.
module fixed_point_to_radix_digits_core import fprd_pkg::*; #(
  parameter int INT_BITS  = 32,
  parameter int FRAC_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // Input item stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,    // [31:0] value_int, [63:32] value_frac
  // Output character stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [6:0] char_code, [7] zero
  output logic        m_tlast,    // last
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers. Writes are to be issued only while the block is idle; the block does not enforce this.
  logic [RADIX_W-1:0] radix_reg;
  logic [PREC_W-1:0]  precision_reg;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_reg     <= RADIX_RESET;
      precision_reg <= PREC_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_RADIX:     radix_reg     <= pwdata[RADIX_W-1:0];
        REG_PRECISION: precision_reg <= pwdata[PREC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_RADIX:     prdata = {{(32-RADIX_W){1'b0}}, radix_reg};
      REG_PRECISION: prdata = {{(32-PREC_W){1'b0}}, precision_reg};
      default:       prdata = '0;
    endcase
  end

  // Sequencer state and working registers.
  fprd_state_t        state, state_next;
  logic [RADIX_W-1:0] r_eff, r_eff_next;
  logic [PREC_W-1:0]  prec, prec_next;
  logic [FRAC_BITS-1:0] frac, frac_next;
  logic [COUNT_W-1:0] dcnt, dcnt_next;
  logic [PREC_W-1:0]  fcnt, fcnt_next;
  logic               out_valid, out_valid_next;
  logic [CHAR_W-1:0]  out_char, out_char_next;
  logic               out_last, out_last_next;

  // Shared divider and digit buffer.
  logic               div_start;
  logic [INT_BITS-1:0] div_dividend;
  logic [RADIX_W-1:0] div_divisor;
  logic               div_done;
  logic [INT_BITS-1:0] div_quotient;
  logic [RADIX_W-1:0] div_remainder;

  logic               ram_we;
  logic               ram_re;
  logic [RADIX_W-1:0] ram_rdata;
  logic [COUNT_W-1:0] dcnt_m1;
  logic [COUNT_W-1:0] dcnt_p1;

  fprd_div #(.WIDTH(INT_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  fprd_ram #(.WIDTH(RADIX_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (dcnt[STORE_AW-1:0]),
    .wdata (div_remainder),
    .re    (ram_re),
    .raddr (dcnt_m1[STORE_AW-1:0]),
    .rdata (ram_rdata)
  );

  assign dcnt_m1 = dcnt - 1'b1;
  assign dcnt_p1 = dcnt + 1'b1;

  // Fraction step: one narrow multiply by the radix per digit. The bits above
  // the binary point give the digit, the rest is the remaining fraction.
  logic [FRAC_BITS+RADIX_W-1:0] prod;
  logic [RADIX_W-1:0]           frac_digit;
  logic [FRAC_BITS-1:0]         frac_rest;
  logic                         frac_more;
  logic                         frac_stop;
  logic                         out_free;
  logic                         in_accept;
  logic [INT_BITS-1:0]          in_int;

  assign prod       = (FRAC_BITS+RADIX_W)'(frac) * (FRAC_BITS+RADIX_W)'(r_eff);
  assign frac_digit = prod[FRAC_BITS +: RADIX_W];
  assign frac_rest  = prod[FRAC_BITS-1:0];
  assign frac_more  = (fcnt < prec) && (frac != '0);
  assign frac_stop  = ((fcnt + 1'b1) == prec) || (frac_rest == '0);

  // The output register can take a new character when empty or draining.
  assign out_free  = !out_valid || m_tready;
  assign s_tready  = (state == S_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign in_int    = s_tdata[INT_BITS-1:0];

  always_comb begin
    state_next     = state;
    r_eff_next     = r_eff;
    prec_next      = prec;
    frac_next      = frac;
    dcnt_next      = dcnt;
    fcnt_next      = fcnt;
    out_valid_next = out_valid && !m_tready;
    out_char_next  = out_char;
    out_last_next  = out_last;
    div_start      = 1'b0;
    div_dividend   = in_int;
    div_divisor    = r_eff;
    ram_we         = 1'b0;
    ram_re         = 1'b0;

    case (state)
      S_IDLE: begin
        div_divisor = sat_radix(radix_reg);
        if (in_accept) begin
          r_eff_next = sat_radix(radix_reg);
          prec_next  = precision_reg;
          frac_next  = s_tdata[32 +: FRAC_BITS];
          dcnt_next  = '0;
          if (in_int != '0) begin
            div_start  = 1'b1;
            state_next = S_DIV;
          end else begin
            state_next = S_DOT;
          end
        end
      end

      // Each finished division leaves one digit, least significant first.
      S_DIV: begin
        if (div_done) begin
          ram_we    = 1'b1;
          dcnt_next = dcnt_p1;
          if (div_quotient != '0 && dcnt_p1 < COUNT_W'(STORE_DEPTH)) begin
            div_start    = 1'b1;
            div_dividend = div_quotient;
          end else begin
            state_next = S_RD;
          end
        end
      end

      // Read the buffer back from the top so digits leave most significant first.
      S_RD: begin
        ram_re     = 1'b1;
        state_next = S_EMIT_INT;
      end

      S_EMIT_INT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_char_next  = glyph(ram_rdata);
          out_last_next  = 1'b0;
          dcnt_next      = dcnt_m1;
          state_next     = (dcnt_m1 == '0) ? S_DOT : S_RD;
        end
      end

      S_DOT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_char_next  = CHAR_DOT;
          out_last_next  = 1'b0;
          fcnt_next      = '0;
          state_next     = S_FRAC;
        end
      end

      // When no fraction digit is due on entry, a lone '0' closes the text.
      S_FRAC: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          if (frac_more) begin
            out_char_next = glyph(frac_digit);
            out_last_next = frac_stop;
            frac_next     = frac_rest;
            fcnt_next     = fcnt + 1'b1;
            if (frac_stop) begin
              state_next = S_IDLE;
            end
          end else begin
            out_char_next = CHAR_ZERO;
            out_last_next = 1'b1;
            state_next    = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      dcnt      <= '0;
      fcnt      <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      dcnt      <= dcnt_next;
      fcnt      <= fcnt_next;
    end
  end

  always_ff @(posedge clk) begin
    r_eff    <= r_eff_next;
    prec     <= prec_next;
    frac     <= frac_next;
    out_char <= out_char_next;
    out_last <= out_last_next;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_char};
  assign m_tlast  = out_last;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the integer digit phase");

  a_digit_count_bound: assert property (@(posedge clk) disable iff (rst)
    dcnt <= COUNT_W'(STORE_DEPTH))
    else $error("digit count beyond buffer depth");

  a_emit_has_digit: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD || state == S_EMIT_INT) |-> dcnt != '0)
    else $error("buffer readback with no digit stored");

  a_frac_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_FRAC && fcnt != '0) |-> fcnt < prec)
    else $error("fraction digit count reached precision without stopping");

  a_legal_char: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_char == CHAR_DOT ||
                  (out_char >= CHAR_ZERO && out_char <= 7'h39) ||
                  (out_char >= CHAR_A && out_char <= 7'h5A)))
    else $error("illegal output character");

endmodule
